// ===== src/assert_macros.svh =====
// assertion macros shared by the generator modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== src/mtg_pkg.sv =====
// package: constants, state type and command/status structs of the generator
package mtg_pkg;

   localparam int unsigned StateWords  = 624;
   localparam int unsigned TwistOffset = 397;
   localparam int unsigned AddrBits    = $clog2(StateWords);

   localparam logic [31:0] TwistMatrix = 32'h9908_B0DF;
   localparam logic [31:0] LowerMask   = 32'h7FFF_FFFF;
   localparam logic [31:0] UpperMask   = 32'h8000_0000;
   localparam logic [31:0] InitMult    = 32'h6C07_8965;
   localparam logic [31:0] DefaultSeed = 32'd5489;
   localparam logic [31:0] TemperB     = 32'h9D2C_5680;
   localparam logic [31:0] TemperC     = 32'hEFC6_0000;

   localparam logic [AddrBits-1:0] LastAddr = AddrBits'(StateWords - 1);
   localparam logic [AddrBits-1:0] FarWrap  = AddrBits'(StateWords - TwistOffset);
   localparam logic [AddrBits-1:0] FarAdd   = AddrBits'(TwistOffset);
   localparam logic [AddrBits-1:0] FarSub   = AddrBits'(StateWords - TwistOffset);

   localparam logic OpDraw   = 1'b0;
   localparam logic OpReseed = 1'b1;

   typedef enum logic [1:0] {
      ST_FILL,
      ST_IDLE,
      ST_TWIST
   } state_type;

   typedef struct packed {
      logic load_seed;
      logic fill_step;
      logic draw_done;
   } cmd_type;

   typedef struct packed {
      logic fill_last;
      logic out_free;
   } status_type;

   function automatic logic [31:0] temper(input logic [31:0] w);
      logic [31:0] y;
      y = w ^ (w >> 11);
      y = y ^ ((y << 7) & TemperB);
      y = y ^ ((y << 15) & TemperC);
      y = y ^ (y >> 18);
      return y;
   endfunction

endpackage

// ===== src/mt19937_generator_top.sv =====
// top level of the mt19937 pseudo-random word generator
//
// request channel: req_valid/req_stall with req_operation and req_seed_value.
//   a draw beat (operation 0) returns one tempered 32-bit word; a reseed beat
//   (operation 1) refills the 624-word state from req_seed_value and returns
//   nothing.
// response channel: rsp_valid/rsp_stall with rsp_random_word, one beat per draw.
// a draw is taken in ST_IDLE and its word is twisted from three state words
//   in ST_TWIST, which waits while a stalled response holds the output
//   register; the tempered word then enters it and rsp_valid rises. the
//   state ram's registered reads come ahead of the one-word twist, and no
//   new draw is taken until ST_TWIST ends.
// a reseed refills the state one word per cycle from the seed through the
//   initialisation multiplier; no request is taken meanwhile.
// after reset the same fill runs with seed 5489, req_stall high until it ends.
// a stalled response stays in the output register; one further draw may
//   complete its reads and then waits, and req_stall stays high until the
//   held word is taken.
module mt19937_generator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [31:0] req_seed_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_random_word
);

   import mtg_pkg::*;

   cmd_type    cmd;
   status_type status;

   mtg_controller u_controller (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_stall     (req_stall),
      .cmd           (cmd),
      .status        (status)
   );

   mtg_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_seed_value  (req_seed_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_random_word (rsp_random_word)
   );

endmodule

// ===== src/mtg_ram.sv =====
// generic ram: one write port, two registered read ports
module mtg_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 624
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

// ===== src/mtg_datapath.sv =====
// datapath: seeding recurrence, per-word twist, tempering and result register
`include "assert_macros.svh"

module mtg_datapath (
   input  logic                clock,
   input  logic                reset,
   input  mtg_pkg::cmd_type    cmd,
   output mtg_pkg::status_type status,
   input  logic [31:0]         req_seed_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [31:0]         rsp_random_word
);

   import mtg_pkg::*;

   logic [AddrBits-1:0] idx_ff, idx_in;
   logic [AddrBits-1:0] fill_ff, fill_in;
   logic [31:0]         seed_ff, seed_in;
   logic [31:0]         prev_ff, prev_in;
   logic [31:0]         cur_ff, cur_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [31:0]         rsp_word_ff, rsp_word_in;

   logic [AddrBits-1:0] nxt_addr, far_addr, wr_addr;
   logic [31:0]         rd_nxt, rd_far;
   logic [31:0]         mix, fill_word, twist_y, twist_word, wr_data;
   logic                wr_en;

   // addresses of the neighbour and the far word of the current position
   assign nxt_addr = (idx_ff == LastAddr) ? '0 : idx_ff + 1'b1;
   assign far_addr = (idx_ff < FarWrap) ? idx_ff + FarAdd : idx_ff - FarSub;

   // seeding recurrence
   assign mix       = prev_ff ^ (prev_ff >> 30);
   assign fill_word = (fill_ff == '0) ? seed_ff
                                      : (InitMult * mix) + {{(32-AddrBits){1'b0}}, fill_ff};

   // one word of the twist, computed when it is drawn
   assign twist_y    = (cur_ff & UpperMask) | (rd_nxt & LowerMask);
   assign twist_word = rd_far ^ (twist_y >> 1) ^ (twist_y[0] ? TwistMatrix : '0);

   assign wr_en   = cmd.fill_step | cmd.draw_done;
   assign wr_addr = cmd.fill_step ? fill_ff : idx_ff;
   assign wr_data = cmd.fill_step ? fill_word : twist_word;

   mtg_ram #(
      .WIDTH (32),
      .DEPTH (StateWords)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (nxt_addr),
      .rd_data_a (rd_nxt),
      .rd_addr_b (far_addr),
      .rd_data_b (rd_far)
   );

   always_comb begin
      idx_in       = idx_ff;
      fill_in      = fill_ff;
      seed_in      = seed_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_word_in  = rsp_word_ff;
      if (cmd.load_seed) begin
         seed_in = req_seed_value;
         fill_in = '0;
      end
      if (cmd.fill_step) begin
         prev_in = fill_word;
         fill_in = fill_ff + 1'b1;
         if (fill_ff == LastAddr) begin
            idx_in = '0;
            cur_in = seed_ff;
         end
      end
      if (cmd.draw_done) begin
         idx_in       = nxt_addr;
         cur_in       = rd_nxt;
         rsp_valid_in = 1'b1;
         rsp_word_in  = temper(twist_word);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         fill_ff      <= '0;
         seed_ff      <= DefaultSeed;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         fill_ff      <= fill_in;
         seed_ff      <= seed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      prev_ff     <= prev_in;
      cur_ff      <= cur_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign status.fill_last = (fill_ff == LastAddr);
   assign status.out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_random_word  = rsp_word_ff;

   `ASSERT_NEXT(a_draw_loads_rsp, clock, reset, cmd.draw_done, rsp_valid_ff)
   `ASSERT_IMPLIES(a_idx_range, clock, reset, 1'b1, idx_ff <= LastAddr)

endmodule

// ===== src/mtg_controller.sv =====
// controller: state machine sequencing seeding and draws
`include "assert_macros.svh"

module mtg_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_operation,
   output logic                req_stall,
   output mtg_pkg::cmd_type    cmd,
   input  mtg_pkg::status_type status
);

   import mtg_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_FILL: begin
            cmd.fill_step = 1'b1;
            if (status.fill_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_operation == OpReseed) begin
                  cmd.load_seed = 1'b1;
                  state_in      = ST_FILL;
               end else begin
                  state_in = ST_TWIST;
               end
            end
         end
         ST_TWIST: begin
            if (status.out_free) begin
               cmd.draw_done = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `ASSERT_NEXT(a_draw_enters_twist, clock, reset,
      req_valid && !req_stall && req_operation == OpDraw, state_ff == ST_TWIST)
   `ASSERT_NEXT(a_reseed_enters_fill, clock, reset,
      req_valid && !req_stall && req_operation == OpReseed, state_ff == ST_FILL)
   `ASSERT_IMPLIES(a_draw_needs_room, clock, reset, cmd.draw_done, status.out_free)
   `ASSERT_IMPLIES(a_one_command, clock, reset, 1'b1, $onehot0(cmd))

endmodule
